// ===== hdl/dct_pkg.sv =====
// Shared types, widths and codes for the distinct colour tracker.
package dct_pkg;

    localparam int LABEL_W    = 10;
    localparam int COLOR_W    = 8;
    localparam int DISTINCT_W = 8;
    localparam int LABEL_SPAN = 1 << LABEL_W;
    localparam int COLOR_SPAN = 1 << COLOR_W;

    localparam logic [LABEL_W-1:0] HIGHEST_LABEL_RST = '1;

    typedef struct packed {
        logic [LABEL_W-1:0] ball_label;
        logic [COLOR_W-1:0] new_color;
    } t_in_item;

    typedef struct packed {
        logic [DISTINCT_W-1:0] distinct_colors;
        logic                  label_rejected;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DEC,
        ST_INC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic write_slot;
        logic rd_pop_old;
        logic rd_pop_new;
        logic dec;
        logic inc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic skip;
        logic same;
        logic need_dec;
        logic need_inc;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/dct_controller.sv =====
// Sequencing state machine for the distinct colour tracker.
module dct_controller
    import dct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (i_status.skip || i_status.same) begin
                    n_state = ST_DONE;
                end else if (i_status.need_dec) begin
                    n_state = ST_DEC;
                end else if (i_status.need_inc) begin
                    n_state = ST_INC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DEC: begin
                n_state = i_status.need_inc ? ST_INC : ST_DONE;
            end
            ST_INC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_LOOKUP: begin
                if (!i_status.skip && !i_status.same) begin
                    o_cmd.write_slot = 1'b1;
                    if (i_status.need_dec) begin
                        o_cmd.rd_pop_old = 1'b1;
                    end else if (i_status.need_inc) begin
                        o_cmd.rd_pop_new = 1'b1;
                    end
                end
            end
            ST_DEC: begin
                o_cmd.dec        = 1'b1;
                o_cmd.rd_pop_new = i_status.need_inc;
            end
            ST_INC: begin
                o_cmd.inc = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/dct_datapath.sv =====
// Slot colour store, population store, distinct count and result register.
module dct_datapath
    import dct_pkg::*;
#(
    parameter int NUM_SLOTS  = 1024,
    parameter int NUM_COLORS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_we,
    input  logic [LABEL_W-1:0] i_cfg_wdata,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    // Only labels and colours that the field widths can name need storage
    localparam int SLOT_DEPTH  = (NUM_SLOTS < LABEL_SPAN) ? NUM_SLOTS : LABEL_SPAN;
    localparam int COLOR_DEPTH = (NUM_COLORS < COLOR_SPAN) ? NUM_COLORS : COLOR_SPAN;
    localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
    localparam int COLOR_AW    = $clog2(COLOR_DEPTH);
    localparam int POP_W       = $clog2(SLOT_DEPTH + 1);
    localparam int CLR_LEN     = (SLOT_DEPTH > COLOR_DEPTH) ? SLOT_DEPTH : COLOR_DEPTH;
    localparam int CLR_W       = $clog2(CLR_LEN);
    localparam logic [LABEL_W-1:0] SLOT_LAST  = LABEL_W'(SLOT_DEPTH - 1);
    localparam logic [COLOR_W-1:0] COLOR_LAST = COLOR_W'(COLOR_DEPTH - 1);

    logic [COLOR_W-1:0]    r_slot_mem [SLOT_DEPTH];
    logic [POP_W-1:0]      r_pop_mem  [COLOR_DEPTH];

    logic [LABEL_W-1:0]    r_highest_label;
    logic [LABEL_W-1:0]    r_label;
    logic [COLOR_W-1:0]    r_color;
    logic                  r_rejected;
    logic                  r_color_bad;
    logic [COLOR_W-1:0]    r_slot_q;
    logic [POP_W-1:0]      r_pop_q;
    logic [DISTINCT_W-1:0] r_distinct;
    logic [CLR_W-1:0]      r_clr;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  clr_in_slots;
    logic                  clr_in_colors;
    logic                  slot_we;
    logic [SLOT_AW-1:0]    slot_wa;
    logic [COLOR_W-1:0]    slot_wd;
    logic                  pop_re;
    logic [COLOR_AW-1:0]   pop_ra;
    logic                  pop_we;
    logic [COLOR_AW-1:0]   pop_wa;
    logic [POP_W-1:0]      pop_wd;

    assign clr_in_slots  = ({1'b0, r_clr} < (CLR_W + 1)'(SLOT_DEPTH));
    assign clr_in_colors = ({1'b0, r_clr} < (CLR_W + 1)'(COLOR_DEPTH));

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest_label <= HIGHEST_LABEL_RST;
        end else if (i_cfg_we) begin
            r_highest_label <= i_cfg_wdata;
        end
    end

    // Capture the transaction and its range checks
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_label     <= i_in.ball_label;
            r_color     <= i_in.new_color;
            r_rejected  <= (i_in.ball_label > r_highest_label) ||
                           (i_in.ball_label > SLOT_LAST);
            r_color_bad <= (i_in.new_color > COLOR_LAST);
        end
    end

    // Slot colour store
    assign slot_we = (i_cmd.clr_step && clr_in_slots) || i_cmd.write_slot;
    assign slot_wa = i_cmd.clr_step ? r_clr[SLOT_AW-1:0] : r_label[SLOT_AW-1:0];
    assign slot_wd = i_cmd.clr_step ? '0 : r_color;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
        if (i_cmd.capture) begin
            r_slot_q <= r_slot_mem[i_in.ball_label[SLOT_AW-1:0]];
        end
    end

    // Population store
    assign pop_re = i_cmd.rd_pop_old || i_cmd.rd_pop_new;
    assign pop_ra = i_cmd.rd_pop_old ? r_slot_q[COLOR_AW-1:0] : r_color[COLOR_AW-1:0];
    assign pop_we = (i_cmd.clr_step && clr_in_colors) ||
                    (i_cmd.dec && (r_pop_q != '0)) || i_cmd.inc;

    always_comb begin
        if (i_cmd.clr_step) begin
            pop_wa = r_clr[COLOR_AW-1:0];
            pop_wd = '0;
        end else if (i_cmd.dec) begin
            pop_wa = r_slot_q[COLOR_AW-1:0];
            pop_wd = r_pop_q - POP_W'(1);
        end else begin
            pop_wa = r_color[COLOR_AW-1:0];
            pop_wd = r_pop_q + POP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_we) begin
            r_pop_mem[pop_wa] <= pop_wd;
        end
        if (pop_re) begin
            r_pop_q <= r_pop_mem[pop_ra];
        end
    end

    // Distinct count and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distinct <= '0;
            r_clr      <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (i_cmd.dec && (r_pop_q == POP_W'(1)) && (r_distinct != '0)) begin
                r_distinct <= r_distinct - DISTINCT_W'(1);
            end else if (i_cmd.inc && (r_pop_q == '0)) begin
                r_distinct <= r_distinct + DISTINCT_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.distinct_colors <= r_distinct;
            r_out.label_rejected  <= r_rejected;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_status.clr_last = (r_clr == CLR_W'(CLR_LEN - 1));
    assign o_status.skip     = r_rejected || r_color_bad;
    assign o_status.same     = (r_slot_q == r_color);
    assign o_status.need_dec = (r_slot_q != '0) && (r_slot_q <= COLOR_LAST);
    assign o_status.need_inc = (r_color != '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== hdl/distinct_color_tracker_top.sv =====
// Top level of the distinct colour tracker: controller plus datapath.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_in  (ball_label, new_color)
//   out     | output    | o_out_valid / i_out_ready| o_out (distinct_colors, label_rejected)
//   cfg     | input     | i_cfg_we, no wait        | i_cfg_wdata (highest_label)
//
// One transaction is in flight at a time: accept, look up the slot, then read-modify-write
// the old and the new colour's populations on the one population port, then load the result.
// Each population step is skipped when its colour's population does not change, and both are
// skipped when the label is rejected, the colour is out of range or unchanged. Reset starts a
// clearing pass over max(slot depth, colour depth) addresses with o_in_ready low; configuration
// writes are taken throughout. A held result stalls only the final load of the next one.
module distinct_color_tracker_top
    import dct_pkg::*;
#(
    parameter int NUM_SLOTS  = 1024,
    parameter int NUM_COLORS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LABEL_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    t_cmd    cmd;
    t_status status;

    // Sequencing: clear pass, accept, lookup, decrement, increment, deliver
    dct_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Stores, counters and the result register
    dct_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_COLORS (NUM_COLORS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/dct_checker.sv =====
// Port-level checks for the distinct colour tracker, bound to the top level.
module dct_checker
    import dct_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    logic [DISTINCT_W-1:0] r_last;

    // Track the count carried by the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_last <= o_out.distinct_colors;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted while one is in flight");

    a_reject_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.label_rejected |-> o_out.distinct_colors == r_last)
        else $error("rejected label changed the distinct count");

    a_step_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.distinct_colors == r_last) ||
                        (o_out.distinct_colors == r_last + DISTINCT_W'(1)) ||
                        (r_last == o_out.distinct_colors + DISTINCT_W'(1)))
        else $error("distinct count moved by more than one");

endmodule

bind distinct_color_tracker_top dct_checker u_dct_checker (.*);
